// ===== sv/ncd_pkg.sv =====
package ncd_pkg;

   localparam int MAX_CARS   = 8;
   localparam int MAX_FLOORS = 64;
   localparam int CAR_W      = 3;
   localparam int LEVEL_W    = 6;
   localparam int CFG_W      = 4;
   localparam int DIST_W     = 10;

   localparam logic [DIST_W-1:0] NO_CANDIDATE_DIST = DIST_W'(999);

   localparam logic [1:0] MODE_STATUS = 2'd0;
   localparam logic [1:0] MODE_CALL   = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   localparam logic [1:0] MOTION_IDLE = 2'd0;
   localparam logic [1:0] MOTION_UP   = 2'd1;
   localparam logic [1:0] MOTION_DOWN = 2'd2;
   localparam logic [1:0] MOTION_NONE = 2'd3;

   localparam logic DIR_UP   = 1'b0;
   localparam logic DIR_DOWN = 1'b1;

   localparam logic KIND_ASSIGNED = 1'b0;
   localparam logic KIND_DROPPED  = 1'b1;

   typedef struct packed {
      logic [1:0]         mode;
      logic [CAR_W-1:0]   car_index;
      logic [1:0]         car_motion;
      logic [LEVEL_W-1:0] floor_level;
      logic               call_direction;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [LEVEL_W-1:0] out_level;
      logic               out_direction;
      logic [CAR_W-1:0]   out_car;
      logic               last_of_run;
   } rsp_type;

   // one queued hall call
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               dir;
   } call_type;

   // pick result handed from the car compare to the sweep control
   typedef struct packed {
      logic             found;
      logic [CAR_W-1:0] car;
   } pick_type;

endpackage

// ===== sv/ncd_queue_cell.sv =====
module ncd_queue_cell
   import ncd_pkg::*;
(
   input  logic     clock,
   input  logic     shift_en,
   input  call_type shift_in,
   input  logic     load_en,
   input  call_type load_in,
   output call_type entry
);

   call_type entry_ff;

   // a load wins over the shift so a kept call can land at the tail
   always_ff @(posedge clock) begin
      if (load_en) begin
         entry_ff <= load_in;
      end else if (shift_en) begin
         entry_ff <= shift_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== sv/ncd_car_pick.sv =====
module ncd_car_pick
   import ncd_pkg::*;
(
   input  logic [1:0]         car_motion [MAX_CARS],
   input  logic [LEVEL_W-1:0] car_level  [MAX_CARS],
   input  logic [CFG_W-1:0]   cars_in_use,
   input  call_type           call,
   output pick_type           pick
);

   always_comb begin
      logic [DIST_W-1:0]  best_dist;
      logic [LEVEL_W-1:0] span;
      logic               above;
      logic               below;
      logic               ok;
      best_dist = NO_CANDIDATE_DIST;
      pick      = '0;
      for (int c = 0; c < MAX_CARS; c++) begin
         above = call.level > car_level[c];
         below = call.level < car_level[c];
         span  = above ? (call.level - car_level[c]) : (car_level[c] - call.level);
         unique case (car_motion[c])
            MOTION_IDLE: ok = 1'b1;
            MOTION_UP:   ok = (call.dir == DIR_UP) && !below;
            MOTION_DOWN: ok = (call.dir == DIR_DOWN) && !above;
            default:     ok = 1'b0;
         endcase
         if ({1'b0, cars_in_use} <= (CFG_W+1)'(c)) begin
            ok = 1'b0;
         end
         // strict compare keeps the lowest index on a tie
         if (ok && (DIST_W'(span) < best_dist)) begin
            best_dist = DIST_W'(span);
            pick.found = 1'b1;
            pick.car   = CAR_W'(c);
         end
      end
   end

endmodule

// ===== sv/nearest_car_elevator_dispatch.sv =====
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  req_data  (req_type)
// rsp_      out        rsp_valid / rsp_stall  rsp_data  (rsp_type)
// csr_      in         csr_valid / csr_ready  csr_data  (elevators_in_use)
//
// status updates and hall calls are handled on their accept, without a sweep
// a dispatch tick sweeps every queued call once, and no new transaction is accepted
//   until the sweep has ended: the queue chain shifts one call past the car compare
//   each cycle while the output register is free
// reset is synchronous; the car table comes up not eligible, the queue empty
// a stalled result holds the sweep in place; no new transaction is taken until
//   the output register is free
module nearest_car_elevator_dispatch
   import ncd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_SWEEP = 1'b1;

   logic             state_ff, state_in;
   logic [CW-1:0]    len_ff, len_in;     // calls held in the chain
   logic [CW-1:0]    rem_ff, rem_in;     // calls still to be looked at in this sweep
   logic [CFG_W-1:0] cars_ff;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [1:0]         motion_ff [MAX_CARS];
   logic [LEVEL_W-1:0] level_ff  [MAX_CARS];

   call_type cell_q    [QUEUE_DEPTH];
   logic     cell_load [QUEUE_DEPTH];
   call_type load_call;
   logic     load_any;
   logic [CW-1:0] load_idx;

   logic               out_free;
   logic               accept;
   logic               sweep_step;
   logic [LEVEL_W-1:0] req_level;
   pick_type           pick;

   // output register frees up when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // saturate the call level to the top floor
   assign req_level = (req_data.floor_level > LEVEL_W'(MAX_FLOORS - 1)) ?
                      LEVEL_W'(MAX_FLOORS - 1) : req_data.floor_level;

   // one sweep step pops the head cell through the car compare
   assign sweep_step = (state_ff == ST_SWEEP) && (rem_ff != '0) && out_free;

   ncd_car_pick u_pick (
      .car_motion  (motion_ff),
      .car_level   (level_ff),
      .cars_in_use (cars_ff),
      .call        (cell_q[0]),
      .pick        (pick)
   );

   // queue chain: cell i takes cell i+1 on a shift, head is cell 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      call_type nb;
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign nb = cell_q[i];
      end else begin : g_mid
         assign nb = cell_q[i+1];
      end
      assign cell_load[i] = load_any && (load_idx == CW'(i));
      ncd_queue_cell u_cell (
         .clock    (clock),
         .shift_en (sweep_step),
         .shift_in (nb),
         .load_en  (cell_load[i]),
         .load_in  (load_call),
         .entry    (cell_q[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      rem_in        = rem_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      load_any      = 1'b0;
      load_idx      = len_ff;
      load_call     = '{level: req_level, dir: req_data.call_direction};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_CALL: begin
                     if (len_ff < CW'(QUEUE_DEPTH)) begin
                        // append at the tail
                        load_any = 1'b1;
                        len_in   = len_ff + 1'b1;
                     end else begin
                        // queue full: report the call as dropped
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{result_kind:   KIND_DROPPED,
                                         out_level:     req_level,
                                         out_direction: req_data.call_direction,
                                         out_car:       '0,
                                         last_of_run:   1'b1};
                     end
                  end
                  MODE_TICK: begin
                     rem_in   = len_ff;
                     state_in = ST_SWEEP;
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            if (sweep_step) begin
               rem_in = rem_ff - 1'b1;
               if (pick.found) begin
                  // hold the newest assignment back until we know if it is the last
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = '{result_kind:   KIND_ASSIGNED,
                                    out_level:     cell_q[0].level,
                                    out_direction: cell_q[0].dir,
                                    out_car:       pick.car,
                                    last_of_run:   1'b0};
                  len_in        = len_ff - 1'b1;
               end else begin
                  // unassigned call goes back in behind the calls already kept
                  load_any  = 1'b1;
                  load_idx  = len_ff - 1'b1;
                  load_call = cell_q[0];
               end
            end else if (rem_ff == '0) begin
               if (!pend_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in              = pend_ff;
                  rsp_data_in.last_of_run  = 1'b1;
                  pend_valid_in            = 1'b0;
                  state_in                 = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         rem_ff        <= '0;
         cars_ff       <= CFG_W'(1);
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         rem_ff        <= rem_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cars_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // car status table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_CARS; c++) begin
            motion_ff[c] <= MOTION_NONE;
            level_ff[c]  <= '0;
         end
      end else if (accept && (req_data.mode == MODE_STATUS) &&
                   ({1'b0, req_data.car_index} < (CAR_W+1)'(MAX_CARS))) begin
         motion_ff[req_data.car_index] <= req_data.car_motion;
         level_ff[req_data.car_index]  <= req_level;
      end
   end

   // queue occupancy never runs past the chain length
   assert property (@(posedge clock) disable iff (reset)
      len_ff <= CW'(QUEUE_DEPTH))
      else $error("queue length beyond depth");

   // calls still to sweep are always held in the chain
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (rem_ff <= len_ff))
      else $error("sweep count beyond queue length");

   // a held assignment exists only inside a sweep
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held assignment outside sweep");

   // a dropped call is always a single, final result with car zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_kind == KIND_DROPPED)) |->
      (rsp_data.last_of_run && (rsp_data.out_car == '0)))
      else $error("malformed drop result");

endmodule

// ===== verif/nearest_car_elevator_dispatch_test.sv =====
`timescale 1ns / 100ps

module nearest_car_elevator_dispatch_test;
   import ncd_pkg::*;

   // queue size of the block under test and timing of the bench
   localparam int CALL_SLOTS     = 16;
   localparam int DRAIN_CYCLES   = CALL_SLOTS + 4;   // a tick sweep that assigns nothing
   localparam int HOLD_CYCLES    = 120;              // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;

   // mode 3 is not decoded by the block
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data = '0;

   nearest_car_elevator_dispatch #(
      .QUEUE_DEPTH(CALL_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // dispatcher state as the bench sees it
   // ------------------------------------------------------------------
   logic [1:0]         car_motion [MAX_CARS];
   logic [LEVEL_W-1:0] car_level  [MAX_CARS];
   logic [CFG_W-1:0]   cars_enabled = CFG_W'(1);
   call_type           hall_calls [$];        // pending calls, oldest first
   rsp_type            expected_rsps [$];     // assignments and drops still to come

   // stimulus bookkeeping
   req_type pending_reqs [$];
   int      items_queued = 0;
   int      items_accepted = 0;
   int      send_gap_pct = 15;
   int      recv_stall_pct = 15;
   int      holds_asked = 0;
   int      mismatches = 0;

   initial begin
      for (int c = 0; c < MAX_CARS; c++) begin
         car_motion[c] = MOTION_NONE;
         car_level[c]  = '0;
      end
   end

   // nearest eligible car for one call; lowest index wins a tie
   function automatic pick_type nearest_car(input logic [LEVEL_W-1:0] lvl, input logic dir);
      pick_type pick;
      int       enabled;
      int       best_dist;
      int       diff;
      int       span;
      pick      = '0;
      best_dist = int'(NO_CANDIDATE_DIST);
      enabled   = (int'(cars_enabled) > MAX_CARS) ? MAX_CARS : int'(cars_enabled);
      for (int c = 0; c < enabled; c++) begin
         diff = int'(lvl) - int'(car_level[c]);
         span = (diff < 0) ? -diff : diff;
         // up cars only take up calls at or above them, down cars the mirror
         if (car_motion[c] == MOTION_NONE) continue;
         if (car_motion[c] == MOTION_UP && (dir != DIR_UP || diff < 0)) continue;
         if (car_motion[c] == MOTION_DOWN && (dir != DIR_DOWN || diff > 0)) continue;
         if (span < best_dist) begin
            best_dist  = span;
            pick.found = 1'b1;
            pick.car   = CAR_W'(c);
         end
      end
      return pick;
   endfunction

   // apply one accepted transaction and queue the results it causes
   task automatic dispatch_transaction(input req_type t);
      rsp_type  run [$];
      call_type kept [$];
      call_type call;
      pick_type pick;
      rsp_type  r;
      case (t.mode)
         MODE_STATUS: begin
            car_motion[t.car_index] = t.car_motion;
            car_level[t.car_index]  = t.floor_level;
         end
         MODE_CALL: begin
            call.level = t.floor_level;
            call.dir   = t.call_direction;
            if (hall_calls.size() < CALL_SLOTS) begin
               hall_calls.push_back(call);
            end else begin
               // queue full: the call is reported back, not stored
               r               = '0;
               r.result_kind   = KIND_DROPPED;
               r.out_level     = call.level;
               r.out_direction = call.dir;
               run.push_back(r);
            end
         end
         MODE_TICK: begin
            // sweep oldest to newest; calls without a car keep their order
            foreach (hall_calls[i]) begin
               call = hall_calls[i];
               pick = nearest_car(call.level, call.dir);
               if (pick.found) begin
                  r               = '0;
                  r.result_kind   = KIND_ASSIGNED;
                  r.out_level     = call.level;
                  r.out_direction = call.dir;
                  r.out_car       = pick.car;
                  run.push_back(r);
               end else begin
                  kept.push_back(call);
               end
            end
            hall_calls = kept;
         end
         default: ;
      endcase
      foreach (run[i]) begin
         r             = run[i];
         r.last_of_run = (i == run.size() - 1);
         expected_rsps.push_back(r);
      end
   endtask

   // ------------------------------------------------------------------
   // driver: one transaction per handshake, payload held while stalled
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            dispatch_transaction(req_data);
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: random stalls, plus long hold-offs on request
   // ------------------------------------------------------------------
   int hold_left = 0;
   int holds_served = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served = holds_asked;
         hold_left    = HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display({"%0t %s: expected kind %0d level %0d dir %0d car %0d last %0d,",
                   " got kind %0d level %0d dir %0d car %0d last %0d"},
                  $time, what, want.result_kind, want.out_level, want.out_direction,
                  want.out_car, want.last_of_run, got.result_kind, got.out_level,
                  got.out_direction, got.out_car, got.last_of_run);
   endtask

   // ------------------------------------------------------------------
   // monitor: every result transaction against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            note_mismatch("result with none expected", '0, rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.result_kind !== want.result_kind ||
                rsp_data.out_level !== want.out_level ||
                rsp_data.out_direction !== want.out_direction ||
                rsp_data.out_car !== want.out_car ||
                rsp_data.last_of_run !== want.last_of_run)
               note_mismatch("result mismatch", want, rsp_data);
         end
      end
   end

   // watchdog: cycles in a row with no transaction on any channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic req_type status_item(input int car, input logic [1:0] motion,
                                           input int lvl);
      req_type t;
      t             = '0;
      t.mode        = MODE_STATUS;
      t.car_index   = CAR_W'(car);
      t.car_motion  = motion;
      t.floor_level = LEVEL_W'(lvl);
      return t;
   endfunction

   function automatic req_type call_item(input int lvl, input logic dir);
      req_type t;
      t                = '0;
      t.mode           = MODE_CALL;
      t.floor_level    = LEVEL_W'(lvl);
      t.call_direction = dir;
      return t;
   endfunction

   function automatic req_type tick_item();
      req_type t;
      t      = '0;
      t.mode = MODE_TICK;
      return t;
   endfunction

   // random content in every field; mostly eligible cars so ticks assign
   function automatic req_type random_item(input int call_pct, input int tick_pct);
      req_type t;
      int      roll;
      t.car_index      = CAR_W'($urandom_range(MAX_CARS - 1));
      t.car_motion     = 2'($urandom_range(3));
      t.floor_level    = LEVEL_W'($urandom_range(MAX_FLOORS - 1));
      t.call_direction = 1'($urandom_range(1));
      roll             = $urandom_range(99);
      if (roll < call_pct)
         t.mode = MODE_CALL;
      else if (roll < call_pct + tick_pct)
         t.mode = MODE_TICK;
      else if (roll < 97)
         t.mode = MODE_STATUS;
      else
         t.mode = MODE_UNUSED;
      if (t.mode == MODE_STATUS && t.car_motion == MOTION_NONE && $urandom_range(3) != 0)
         t.car_motion = MOTION_IDLE;
      return t;
   endfunction

   task automatic offer(input req_type t);
      pending_reqs.push_back(t);
      items_queued++;
   endtask

   // called right after a rising edge
   task automatic write_car_count(input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cars_enabled = value;
      csr_valid   <= 1'b0;
   endtask

   // sender pauses until every transaction is in and every result is out,
   // then lets a silent sweep finish
   task automatic wait_for_drain();
      @(posedge clock);
      while (items_accepted != items_queued || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] count, input int items,
                            input int call_pct, input int tick_pct,
                            input int gap, input int stall, input bit hold);
      write_car_count(count);
      send_gap_pct   = gap;
      recv_stall_pct = stall;
      if (hold)
         holds_asked++;
      for (int i = 0; i < items; i++)
         offer(random_item(call_pct, tick_pct));
      wait_for_drain();
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      req_type odd;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: car count above the table size saturates to all cars
      write_car_count(CFG_W'(15));
      odd      = '1;
      odd.mode = MODE_UNUSED;
      offer(tick_item());                          // empty queue, nothing assigned
      offer(odd);                                  // unused mode is ignored
      offer(status_item(0, MOTION_IDLE, 0));
      offer(status_item(1, MOTION_IDLE, 0));       // ties with car 0
      offer(status_item(7, MOTION_DOWN, 63));
      offer(status_item(3, MOTION_UP, 20));
      offer(status_item(5, MOTION_NONE, 40));
      offer(call_item(63, DIR_DOWN));              // down car right at the floor
      offer(call_item(0, DIR_UP));                 // tie, lowest index wins
      offer(call_item(30, DIR_UP));                // up car below the call
      offer(call_item(10, DIR_DOWN));
      offer(call_item(40, DIR_DOWN));              // nearest car is not eligible
      offer(call_item(15, DIR_UP));                // up car already past the call
      offer(tick_item());
      offer(status_item(0, MOTION_UP, 63));
      offer(status_item(1, MOTION_DOWN, 0));
      offer(status_item(7, MOTION_NONE, 0));
      offer(status_item(3, MOTION_NONE, 0));
      offer(call_item(63, DIR_UP));
      offer(call_item(0, DIR_DOWN));
      offer(call_item(5, DIR_UP));                 // no eligible car, stays queued
      offer(tick_item());
      offer(status_item(2, MOTION_IDLE, 63));
      offer(tick_item());                          // leftover call now served
      wait_for_drain();

      // no cars: the queue fills and further calls are dropped
      run_phase(CFG_W'(0), 45, 70, 15, 15, 15, 1'b0);
      // all cars, long stretch with no idling on either side
      run_phase(CFG_W'(MAX_CARS), 80, 40, 25, 0, 0, 1'b0);
      run_phase(CFG_W'(1), 50, 40, 25, 15, 15, 1'b0);
      // receiver holds off while the sender keeps offering
      run_phase(CFG_W'(15), 60, 45, 35, 15, 15, 1'b1);
      repeat (4)
         run_phase(CFG_W'($urandom_range(15)), 45, 40, 25, 15, 15, 1'b0);

      if (expected_rsps.size() != 0) begin
         $display("%0d expected results never seen", expected_rsps.size());
         mismatches += expected_rsps.size();
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
